FILE: src/cylinder_mesh_element_generator_defines.svh
// Assertion helpers for the cylinder mesh element generator.
`ifndef CYLINDER_MESH_ELEMENT_GENERATOR_DEFINES_SVH
`define CYLINDER_MESH_ELEMENT_GENERATOR_DEFINES_SVH

// same-cycle implication
`define CMEG_ASSERT_IMP(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (ante) |-> (cons)) \
		else $error("cmeg: implication check failed");

// next-cycle implication
`define CMEG_ASSERT_NXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (ante) |=> (cons)) \
		else $error("cmeg: next-cycle check failed");

`endif

FILE: src/cmeg_pkg.sv
package cmeg_pkg;

	localparam int DEF_MAX_SEGMENTS = 1024;
	localparam int DEF_SINE_ENTRIES = 1024;

	localparam int SEG_W     = 11;
	localparam int IDX_W     = 12;
	localparam int COORD_W   = 32;
	localparam int SINE_W    = 18;   // +-1.0 in Q16 plus sign
	localparam int CFG_IDX_W = 3;
	localparam int SAT_IN_W  = 35;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEGMENTS,
		REG_PHASE_STEP,
		REG_RADIUS_X,
		REG_RADIUS_Z,
		REG_HALF_HEIGHT,
		REG_OFFSET_X,
		REG_OFFSET_Y,
		REG_OFFSET_Z
	} cfg_reg_t;

	typedef enum logic [2:0] {
		KIND_RING_TOP,
		KIND_RING_BOT,
		KIND_CAP_TOP,
		KIND_CAP_BOT,
		KIND_FAN_TOP,
		KIND_FAN_BOT,
		KIND_SIDE_EVEN,
		KIND_SIDE_ODD
	} elem_kind_t;

	localparam logic ACT_VERTEX   = 1'b0;
	localparam logic ACT_TRIANGLE = 1'b1;

	localparam logic [SEG_W-1:0]   RST_SEGMENTS   = 11'd32;
	localparam logic [COORD_W-1:0] RST_PHASE_STEP = 32'h0800_0000;
	localparam logic [COORD_W-1:0] RST_Q16_ONE    = 32'h0001_0000;

	localparam logic signed [SAT_IN_W-1:0] SAT_HI = 35'sh0_7FFF_FFFF;
	localparam logic signed [SAT_IN_W-1:0] SAT_LO = -35'sh0_8000_0000;

	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SAT_IN_W-1:0] v);
		logic [COORD_W-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI[COORD_W-1:0];
		else if (v < SAT_LO)
			r = SAT_LO[COORD_W-1:0];
		else
			r = v[COORD_W-1:0];
		return r;
	endfunction

endpackage

FILE: src/cmeg_sine_lut.sv
module cmeg_sine_lut
	import cmeg_pkg::*;
#(
	parameter int SINE_ENTRIES = DEF_SINE_ENTRIES
) (
	input  logic                              clk,
	input  logic [$clog2(SINE_ENTRIES)-1:0]   k,
	output logic signed [SINE_W-1:0]          sin_s4,
	output logic signed [SINE_W-1:0]          cos_s4
);

	localparam int K_W = $clog2(SINE_ENTRIES);
	localparam int QTR = SINE_ENTRIES / 4;
	localparam int M_W = $clog2(QTR + 1);

	// Quarter-wave entry i holds sin(4i/N * pi/2) in Q16.
	function automatic logic signed [SINE_W-1:0] qsine_entry(input int i);
		longint unsigned m;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned sub;
		longint unsigned one;
		one = 64'd1073741824;
		m = 64'(i) * 64'd4;
		x = (m * 64'd1686629713 + 64'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
		x2 = (x * x) >> 30;
		t = one;
		sub = ((x2 * t) >> 30) / 156;
		t = (sub > one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 110;
		t = (sub > one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 72;
		t = (sub > one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 42;
		t = (sub > one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 20;
		t = (sub > one) ? 64'd0 : one - sub;
		sub = ((x2 * t) >> 30) / 6;
		t = (sub > one) ? 64'd0 : one - sub;
		return SINE_W'((((x * t) >> 30) + 64'd8192) >> 14);
	endfunction

	logic signed [SINE_W-1:0] qsine [QTR+1];

	for (genvar gi = 0; gi <= QTR; gi++) begin : g_qsine
		localparam logic signed [SINE_W-1:0] ENTRY = qsine_entry(gi);
		assign qsine[gi] = ENTRY;
	end

	logic [1:0]     quad;
	logic [1:0]     quad_cos;
	logic [K_W-1:0] rem;
	logic [M_W-1:0] m_sin;
	logic [M_W-1:0] m_cos;

	// k = quad*N/4 + rem, at most three compares
	always_comb begin
		if (k >= K_W'(3 * QTR)) begin
			quad = 2'd3;
			rem  = k - K_W'(3 * QTR);
		end else if (k >= K_W'(2 * QTR)) begin
			quad = 2'd2;
			rem  = k - K_W'(2 * QTR);
		end else if (k >= K_W'(QTR)) begin
			quad = 2'd1;
			rem  = k - K_W'(QTR);
		end else begin
			quad = 2'd0;
			rem  = k;
		end
		quad_cos = quad + 2'd1;
		m_sin = quad[0] ? M_W'(QTR) - M_W'(rem) : M_W'(rem);
		m_cos = quad_cos[0] ? M_W'(QTR) - M_W'(rem) : M_W'(rem);
	end

	always_ff @(posedge clk) begin
		sin_s4 <= quad[1] ? -qsine[m_sin] : qsine[m_sin];
		cos_s4 <= quad_cos[1] ? -qsine[m_cos] : qsine[m_cos];
	end

endmodule

FILE: src/cylinder_mesh_element_generator.sv
// Channel   | Handshake        | Payload
// ----------+------------------+--------------------------------------------
// request   | start / busy     | action, element_index
// result    | done (strobe)    | pos_x, pos_y, pos_z, corner_a..c, out_of_range
// config    | wr_en            | wr_index, wr_data
//
// One request per cycle; each accepted request passes through every stage and leaves on done.
// The pipeline has six stages: decode, ring-phase multiply,
// table-index multiply, sine table, radius multiply, round/offset/saturate.
// busy is always low. arst_n clears valid bits and sets the configuration registers to reset values.
// The receiver cannot stall; each result transaction lasts one cycle.
`include "cylinder_mesh_element_generator_defines.svh"

module cylinder_mesh_element_generator
	import cmeg_pkg::*;
#(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int SINE_ENTRIES = DEF_SINE_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [IDX_W-1:0]            element_index,
	output logic                        done,
	output logic signed [COORD_W-1:0]   pos_x,
	output logic signed [COORD_W-1:0]   pos_y,
	output logic signed [COORD_W-1:0]   pos_z,
	output logic [IDX_W-1:0]            corner_a,
	output logic [IDX_W-1:0]            corner_b,
	output logic [IDX_W-1:0]            corner_c,
	output logic                        out_of_range,
	input  logic                        wr_en,
	input  logic [CFG_IDX_W-1:0]        wr_index,
	input  logic [COORD_W-1:0]          wr_data
);

	localparam int SEG_CAP = (MAX_SEGMENTS < 2047) ? MAX_SEGMENTS : 2047;
	localparam int RING_W  = $clog2(SEG_CAP);
	localparam int EXT_W   = 14;
	localparam int K_W     = $clog2(SINE_ENTRIES);
	localparam int N_W     = $clog2(SINE_ENTRIES + 1);
	localparam int PH_W    = RING_W + COORD_W;
	localparam int KP_W    = COORD_W + N_W;
	localparam int MUL_W   = SINE_W + COORD_W;
	localparam int RND_W   = MUL_W - 16;

	// configuration registers
	logic [SEG_W-1:0]          segments_q;
	logic [COORD_W-1:0]        phase_step_q;
	logic signed [COORD_W-1:0] radius_x_q;
	logic signed [COORD_W-1:0] radius_z_q;
	logic signed [COORD_W-1:0] half_height_q;
	logic signed [COORD_W-1:0] offset_x_q;
	logic signed [COORD_W-1:0] offset_y_q;
	logic signed [COORD_W-1:0] offset_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segments_q    <= RST_SEGMENTS;
			phase_step_q  <= RST_PHASE_STEP;
			radius_x_q    <= RST_Q16_ONE;
			radius_z_q    <= RST_Q16_ONE;
			half_height_q <= RST_Q16_ONE;
			offset_x_q    <= '0;
			offset_y_q    <= '0;
			offset_z_q    <= '0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_SEGMENTS:    segments_q    <= wr_data[SEG_W-1:0];
				REG_PHASE_STEP:  phase_step_q  <= wr_data;
				REG_RADIUS_X:    radius_x_q    <= wr_data;
				REG_RADIUS_Z:    radius_z_q    <= wr_data;
				REG_HALF_HEIGHT: half_height_q <= wr_data;
				REG_OFFSET_X:    offset_x_q    <= wr_data;
				REG_OFFSET_Y:    offset_y_q    <= wr_data;
				REG_OFFSET_Z:    offset_z_q    <= wr_data;
				default:         segments_q    <= segments_q;
			endcase
		end
	end

	assign busy = 1'b0;

	// ---------------- stage 1: decode ----------------
	logic [SEG_W-1:0]  seg_eff;
	logic [EXT_W-1:0]  s_x, two_s, four_s, idx_x, side_k, ring_x;
	elem_kind_t        kind_d;
	logic              oor_d;

	always_comb begin
		if (segments_q < SEG_W'(3))
			seg_eff = SEG_W'(3);
		else if (segments_q > SEG_W'(SEG_CAP))
			seg_eff = SEG_W'(SEG_CAP);
		else
			seg_eff = segments_q;
	end

	assign s_x    = EXT_W'(seg_eff);
	assign two_s  = s_x << 1;
	assign four_s = s_x << 2;
	assign idx_x  = EXT_W'(element_index);
	assign side_k = idx_x - two_s;

	always_comb begin
		kind_d = KIND_RING_TOP;
		ring_x = idx_x;
		if (action == ACT_VERTEX) begin
			oor_d = idx_x > two_s + EXT_W'(1);
			if (idx_x < s_x) begin
				kind_d = KIND_RING_TOP;
			end else if (idx_x < two_s) begin
				kind_d = KIND_RING_BOT;
				ring_x = idx_x - s_x;
			end else if (idx_x == two_s) begin
				kind_d = KIND_CAP_TOP;
			end else begin
				kind_d = KIND_CAP_BOT;
			end
		end else begin
			oor_d = idx_x >= four_s;
			if (idx_x < s_x) begin
				kind_d = KIND_FAN_TOP;
			end else if (idx_x < two_s) begin
				kind_d = KIND_FAN_BOT;
				ring_x = idx_x - s_x;
			end else begin
				kind_d = side_k[0] ? KIND_SIDE_ODD : KIND_SIDE_EVEN;
				ring_x = side_k >> 1;
			end
		end
	end

	// pipeline control and payload
	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic       oor_s1, oor_s2, oor_s3, oor_s4, oor_s5, oor_s6;
	elem_kind_t kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;

	logic [RING_W-1:0]  ring_s1;
	logic [COORD_W-1:0] phase_s2;
	logic [K_W-1:0]     k_s3;
	logic [IDX_W-1:0]   ca_s2, cb_s2, cc_s2;
	logic [IDX_W-1:0]   ca_s3, cb_s3, cc_s3;
	logic [IDX_W-1:0]   ca_s4, cb_s4, cc_s4;
	logic [IDX_W-1:0]   ca_s5, cb_s5, cc_s5;
	logic signed [SINE_W-1:0] sin_s4, cos_s4;
	logic signed [MUL_W-1:0]  prod_x_s5, prod_z_s5;

	logic signed [COORD_W-1:0] pos_x_s6, pos_y_s6, pos_z_s6;
	logic [IDX_W-1:0]          ca_s6, cb_s6, cc_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			oor_s1  <= 1'b0;
			oor_s2  <= 1'b0;
			oor_s3  <= 1'b0;
			oor_s4  <= 1'b0;
			oor_s5  <= 1'b0;
			oor_s6  <= 1'b0;
			kind_s1 <= KIND_RING_TOP;
			kind_s2 <= KIND_RING_TOP;
			kind_s3 <= KIND_RING_TOP;
			kind_s4 <= KIND_RING_TOP;
			kind_s5 <= KIND_RING_TOP;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			oor_s1  <= oor_d;
			oor_s2  <= oor_s1;
			oor_s3  <= oor_s2;
			oor_s4  <= oor_s3;
			oor_s5  <= oor_s4;
			oor_s6  <= oor_s5;
			kind_s1 <= kind_d;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
			kind_s5 <= kind_s4;
		end
	end

	always_ff @(posedge clk) begin
		ring_s1 <= ring_x[RING_W-1:0];
	end

	// ---------------- stage 2: ring phase, triangle corners ----------------
	logic [PH_W-1:0]  phase_full;
	logic [IDX_W-1:0] ring12, seg12, nxt12, two_s12;
	logic [IDX_W-1:0] ca_d, cb_d, cc_d;

	assign phase_full = PH_W'(ring_s1) * PH_W'(phase_step_q);
	assign ring12  = IDX_W'(ring_s1);
	assign seg12   = IDX_W'(seg_eff);
	assign two_s12 = seg12 << 1;
	assign nxt12   = (ring12 + IDX_W'(1) == seg12) ? '0 : ring12 + IDX_W'(1);

	always_comb begin
		ca_d = '0;
		cb_d = '0;
		cc_d = '0;
		case (kind_s1)
			KIND_FAN_TOP: begin
				ca_d = two_s12;
				cb_d = ring12;
				cc_d = nxt12;
			end
			KIND_FAN_BOT: begin
				ca_d = ring12 + seg12;
				cb_d = two_s12 + IDX_W'(1);
				cc_d = nxt12 + seg12;
			end
			KIND_SIDE_EVEN: begin
				ca_d = nxt12;
				cb_d = ring12;
				cc_d = nxt12 + seg12;
			end
			KIND_SIDE_ODD: begin
				ca_d = nxt12 + seg12;
				cb_d = ring12;
				cc_d = ring12 + seg12;
			end
			default: begin
				ca_d = '0;
				cb_d = '0;
				cc_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		phase_s2 <= phase_full[COORD_W-1:0];
		ca_s2    <= ca_d;
		cb_s2    <= cb_d;
		cc_s2    <= cc_d;
	end

	// ---------------- stage 3: table index k = phase*N >> 32 ----------------
	logic [KP_W-1:0] k_full;

	assign k_full = KP_W'(phase_s2) * KP_W'(SINE_ENTRIES);

	always_ff @(posedge clk) begin
		k_s3  <= k_full[COORD_W +: K_W];
		ca_s3 <= ca_s2;
		cb_s3 <= cb_s2;
		cc_s3 <= cc_s2;
	end

	// ---------------- stage 4: sine/cosine lookup ----------------
	cmeg_sine_lut #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_sine_lut (
		.clk    (clk),
		.k      (k_s3),
		.sin_s4 (sin_s4),
		.cos_s4 (cos_s4)
	);

	always_ff @(posedge clk) begin
		ca_s4 <= ca_s3;
		cb_s4 <= cb_s3;
		cc_s4 <= cc_s3;
	end

	// ---------------- stage 5: radius products ----------------
	logic signed [SINE_W-1:0] nsin;

	assign nsin = -sin_s4;

	always_ff @(posedge clk) begin
		prod_x_s5 <= MUL_W'(cos_s4) * MUL_W'(radius_x_q);
		prod_z_s5 <= MUL_W'(nsin) * MUL_W'(radius_z_q);
		ca_s5     <= ca_s4;
		cb_s5     <= cb_s4;
		cc_s5     <= cc_s4;
	end

	// ---------------- stage 6: round, offset, saturate ----------------
	logic signed [MUL_W-1:0]    rsum_x, rsum_z;
	logic signed [RND_W-1:0]    rnd_x, rnd_z;
	logic signed [SAT_IN_W-1:0] sum_x, sum_z, y_top, y_bot;
	logic signed [COORD_W-1:0]  px_d, py_d, pz_d;
	logic [IDX_W-1:0]           oa_d, ob_d, oc_d;

	// round half up: floor(p / 2^16 + 0.5)
	assign rsum_x = prod_x_s5 + MUL_W'(32768);
	assign rsum_z = prod_z_s5 + MUL_W'(32768);
	assign rnd_x  = rsum_x[MUL_W-1:16];
	assign rnd_z  = rsum_z[MUL_W-1:16];
	assign sum_x  = SAT_IN_W'(rnd_x) + SAT_IN_W'(offset_x_q);
	assign sum_z  = SAT_IN_W'(rnd_z) + SAT_IN_W'(offset_z_q);
	assign y_top  = SAT_IN_W'(offset_y_q) + SAT_IN_W'(half_height_q);
	assign y_bot  = SAT_IN_W'(offset_y_q) - SAT_IN_W'(half_height_q);

	always_comb begin
		px_d = '0;
		py_d = '0;
		pz_d = '0;
		oa_d = '0;
		ob_d = '0;
		oc_d = '0;
		if (!oor_s5) begin
			case (kind_s5) inside
				KIND_RING_TOP, KIND_RING_BOT: begin
					px_d = sat_coord(sum_x);
					py_d = sat_coord((kind_s5 == KIND_RING_TOP) ? y_top : y_bot);
					pz_d = sat_coord(sum_z);
				end
				KIND_CAP_TOP, KIND_CAP_BOT: begin
					px_d = offset_x_q;
					py_d = sat_coord((kind_s5 == KIND_CAP_TOP) ? y_top : y_bot);
					pz_d = offset_z_q;
				end
				default: begin
					oa_d = ca_s5;
					ob_d = cb_s5;
					oc_d = cc_s5;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pos_x_s6 <= px_d;
		pos_y_s6 <= py_d;
		pos_z_s6 <= pz_d;
		ca_s6    <= oa_d;
		cb_s6    <= ob_d;
		cc_s6    <= oc_d;
	end

	assign done         = vld_s6;
	assign out_of_range = oor_s6;
	assign pos_x        = pos_x_s6;
	assign pos_y        = pos_y_s6;
	assign pos_z        = pos_z_s6;
	assign corner_a     = ca_s6;
	assign corner_b     = cb_s6;
	assign corner_c     = cc_s6;

	// every result traces back to one accepted request
	`CMEG_ASSERT_IMP(a_done_from_start, clk, arst_n, done, $past(start && !busy, 6))
	`CMEG_ASSERT_NXT(a_start_enters, clk, arst_n, start && !busy, vld_s1)
	`CMEG_ASSERT_IMP(a_oor_zero, clk, arst_n, done && out_of_range,
		pos_x == '0 && pos_y == '0 && pos_z == '0 &&
		corner_a == '0 && corner_b == '0 && corner_c == '0)
	// a point never carries corner indices
	`CMEG_ASSERT_IMP(a_vertex_no_corners, clk, arst_n,
		done && (pos_x != '0 || pos_y != '0 || pos_z != '0),
		corner_a == '0 && corner_b == '0 && corner_c == '0)

endmodule

FILE: tb/cylinder_mesh_element_checker.sv
`timescale 1ns / 100ps

module cylinder_mesh_element_checker
	import cmeg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      action,
	input  logic [IDX_W-1:0]          element_index,
	input  logic                      done,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic [IDX_W-1:0]          corner_a,
	input  logic [IDX_W-1:0]          corner_b,
	input  logic [IDX_W-1:0]          corner_c,
	input  logic                      out_of_range,
	input  logic                      wr_en,
	input  logic [CFG_IDX_W-1:0]      wr_index,
	input  logic [COORD_W-1:0]        wr_data,
	output int                        mismatches,
	output int                        in_flight,
	output int                        checked
);

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [IDX_W-1:0]   a;
		logic [IDX_W-1:0]   b;
		logic [IDX_W-1:0]   c;
		logic               oor;
	} mesh_elem_t;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
	localparam longint unsigned TABLE_N     = DEF_SINE_ENTRIES;

	logic [SEG_W-1:0]          segments;
	logic [COORD_W-1:0]        phase_step;
	logic signed [COORD_W-1:0] radius_x;
	logic signed [COORD_W-1:0] radius_z;
	logic signed [COORD_W-1:0] half_height;
	logic signed [COORD_W-1:0] offset_x;
	logic signed [COORD_W-1:0] offset_y;
	logic signed [COORD_W-1:0] offset_z;

	mesh_elem_t expected_elems[$];

	// sin(m/N * pi/2) in Q16, integer Taylor series in Q30
	function automatic longint quarter_wave(input longint unsigned m);
		longint unsigned divs [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned sub;
		x = (m * Q30_HALF_PI + TABLE_N / 2) / TABLE_N;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		for (int j = 0; j < 6; j++) begin
			sub = ((x2 * t) >> 30) / divs[j];
			t = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
		end
		return longint'((((x * t) >> 30) + 64'd8192) >> 14);
	endfunction

	function automatic longint sine_entry(input logic [1:0] quadrant, input longint unsigned r);
		longint unsigned m;
		longint v;
		m = quadrant[0] ? TABLE_N - r : r;
		v = quarter_wave(m);
		return quadrant[1] ? -v : v;
	endfunction

	// round to nearest Q16.16, ties up (floor of p + 0.5)
	function automatic longint scale_q16(input longint a, input logic signed [COORD_W-1:0] rad);
		longint p;
		p = a * longint'(rad);
		return (p + 64'sd32768) >>> 16;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[COORD_W-1:0];
	endfunction

	function automatic mesh_elem_t predict_element(input logic act, input logic [IDX_W-1:0] idx);
		mesh_elem_t res;
		int s;
		int i;
		int k;
		int nx;
		longint hh;
		longint sn;
		longint cs;
		logic [COORD_W-1:0] ph;
		longint unsigned phw;
		longint unsigned four_k;
		longint unsigned quad;
		longint unsigned rem;
		res = '0;
		s = int'(segments);
		if (s < 3)
			s = 3;
		if (s > DEF_MAX_SEGMENTS)
			s = DEF_MAX_SEGMENTS;
		if (act == ACT_VERTEX) begin
			if (int'(idx) > 2 * s + 1) begin
				res.oor = 1'b1;
			end else begin
				hh = (int'(idx) < s || int'(idx) == 2 * s) ?
					longint'(half_height) : -longint'(half_height);
				res.y = clamp_coord(hh + longint'(offset_y));
				if (int'(idx) >= 2 * s) begin
					res.x = clamp_coord(longint'(offset_x));
					res.z = clamp_coord(longint'(offset_z));
				end else begin
					i = (int'(idx) < s) ? int'(idx) : int'(idx) - s;
					ph = phase_step * 32'(i);
					phw = 64'(ph);
					four_k = 4 * ((phw * TABLE_N) >> 32);
					quad = four_k / TABLE_N;
					rem = four_k - quad * TABLE_N;
					sn = sine_entry(quad[1:0], rem);
					cs = sine_entry(quad[1:0] + 2'd1, rem);
					res.x = clamp_coord(scale_q16(cs, radius_x) + longint'(offset_x));
					res.z = clamp_coord(scale_q16(-sn, radius_z) + longint'(offset_z));
				end
			end
		end else if (int'(idx) >= 4 * s) begin
			res.oor = 1'b1;
		end else if (int'(idx) < s) begin
			i = int'(idx);
			nx = (i + 1 == s) ? 0 : i + 1;
			res.a = IDX_W'(2 * s);
			res.b = IDX_W'(i);
			res.c = IDX_W'(nx);
		end else if (int'(idx) < 2 * s) begin
			i = int'(idx) - s;
			nx = (i + 1 == s) ? 0 : i + 1;
			res.a = IDX_W'(i + s);
			res.b = IDX_W'(2 * s + 1);
			res.c = IDX_W'(nx + s);
		end else begin
			k = int'(idx) - 2 * s;
			i = k >> 1;
			nx = (i + 1 == s) ? 0 : i + 1;
			if (k[0] == 1'b0) begin
				res.a = IDX_W'(nx);
				res.b = IDX_W'(i);
				res.c = IDX_W'(nx + s);
			end else begin
				res.a = IDX_W'(nx + s);
				res.b = IDX_W'(i);
				res.c = IDX_W'(i + s);
			end
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		mesh_elem_t want;
		if (!arst_n) begin
			segments <= RST_SEGMENTS;
			phase_step <= RST_PHASE_STEP;
			radius_x <= RST_Q16_ONE;
			radius_z <= RST_Q16_ONE;
			half_height <= RST_Q16_ONE;
			offset_x <= '0;
			offset_y <= '0;
			offset_z <= '0;
			expected_elems.delete();
			mismatches = 0;
			checked = 0;
			in_flight <= 0;
		end else begin
			if (done) begin
				if (expected_elems.size() == 0) begin
					$display("%0t: result transaction with nothing expected", $time);
					mismatches++;
				end else begin
					want = expected_elems.pop_front();
					check_field("pos_x", want.x, pos_x);
					check_field("pos_y", want.y, pos_y);
					check_field("pos_z", want.z, pos_z);
					check_field("corner_a", 32'(want.a), 32'(corner_a));
					check_field("corner_b", 32'(want.b), 32'(corner_b));
					check_field("corner_c", 32'(want.c), 32'(corner_c));
					check_field("out_of_range", 32'(want.oor), 32'(out_of_range));
					checked++;
				end
			end
			if (wr_en) begin
				case (cfg_reg_t'(wr_index))
					REG_SEGMENTS:    segments <= wr_data[SEG_W-1:0];
					REG_PHASE_STEP:  phase_step <= wr_data;
					REG_RADIUS_X:    radius_x <= wr_data;
					REG_RADIUS_Z:    radius_z <= wr_data;
					REG_HALF_HEIGHT: half_height <= wr_data;
					REG_OFFSET_X:    offset_x <= wr_data;
					REG_OFFSET_Y:    offset_y <= wr_data;
					REG_OFFSET_Z:    offset_z <= wr_data;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_elems.insert(expected_elems.size(),
					predict_element(action, element_index));
			in_flight <= expected_elems.size();
		end
	end

endmodule

FILE: tb/cylinder_mesh_element_generator_test.sv
`timescale 1ns / 100ps

module cylinder_mesh_element_generator_test;
	import cmeg_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int ITEMS_PER_SETTING = 170;
	localparam int SETTINGS = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start;
	logic busy;
	logic action;
	logic [IDX_W-1:0] element_index;
	logic done;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [IDX_W-1:0] corner_a;
	logic [IDX_W-1:0] corner_b;
	logic [IDX_W-1:0] corner_c;
	logic out_of_range;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [COORD_W-1:0] wr_data;

	int mismatches;
	int in_flight;
	int checked;
	int stall_cycles = 0;
	int seg_eff;
	bit idle_on;
	int vertex_reqs = 0;
	int triangle_reqs = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cylinder_mesh_element_generator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .element_index(element_index), .done(done),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.out_of_range(out_of_range),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	cylinder_mesh_element_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .element_index(element_index), .done(done),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.out_of_range(out_of_range),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.mismatches(mismatches), .in_flight(in_flight), .checked(checked)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic int clamp_segments(input logic [SEG_W-1:0] raw);
		if (raw < 3)
			return 3;
		if (raw > DEF_MAX_SEGMENTS)
			return DEF_MAX_SEGMENTS;
		return int'(raw);
	endfunction

	function automatic logic [COORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return RST_Q16_ONE;
			4: return 32'hFFFF_0000;
			5: return $urandom >> $urandom_range(0, 16);
			default: return $urandom;
		endcase
	endfunction

	// mix of ring/cap/fan/side boundaries, in-range and arbitrary indices
	function automatic logic [IDX_W-1:0] pick_index(input logic act);
		int s;
		int lim;
		int sel;
		int idx;
		s = seg_eff;
		lim = (act == ACT_TRIANGLE) ? 4 * s - 1 : 2 * s + 1;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			case ($urandom_range(0, 9))
				0: idx = 0;
				1: idx = s - 1;
				2: idx = s;
				3: idx = 2 * s - 1;
				4: idx = 2 * s;
				5: idx = 2 * s + 1;
				6: idx = 2 * s + 2;
				7: idx = 4 * s - 2;
				8: idx = 4 * s - 1;
				default: idx = 4 * s;
			endcase
		end else if (sel < 88) begin
			idx = $urandom_range(0, lim);
		end else begin
			idx = $urandom_range(0, 4095);
		end
		return IDX_W'(idx);
	endfunction

	task automatic send_request(input logic act, input logic [IDX_W-1:0] idx);
		while (idle_on && $urandom_range(0, 99) < 34) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		element_index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (act == ACT_TRIANGLE)
			triangle_reqs++;
		else
			vertex_reqs++;
	endtask

	task automatic send_random();
		logic act;
		act = 1'($urandom_range(0, 1));
		send_request(act, pick_index(act));
	endtask

	task automatic drain();
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	task automatic load_setting(input int p);
		logic [COORD_W-1:0] vals [8];
		for (int n = 0; n < 8; n++)
			vals[n] = pick_word();
		case (p)
			1: begin
				// minimum ring, full-scale geometry: sums can saturate
				vals = '{32'd3, 32'd1431655765, 32'h7FFF_FFFF, 32'h8000_0000,
					32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
			end
			2: begin
				vals = '{32'd1024, 32'h0040_0000, 32'h8000_0000, 32'h7FFF_FFFF,
					32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
			end
			3: begin
				// segment count below minimum is treated as 3
				vals = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
			end
			4: begin
				vals[REG_SEGMENTS] = 32'd2047;
				vals[REG_PHASE_STEP] = $urandom;
			end
			5: vals[REG_SEGMENTS] = $urandom_range(100, 1024);
			6: vals[REG_SEGMENTS] = $urandom_range(3, 64);
			7: begin
				vals[REG_SEGMENTS] = $urandom;
				vals[REG_PHASE_STEP] = $urandom;
			end
			default: vals[REG_SEGMENTS] = $urandom_range(3, 12);
		endcase
		seg_eff = clamp_segments(vals[REG_SEGMENTS][SEG_W-1:0]);
		if (p == 5 || p == 8 || (p == 6 && $urandom_range(0, 1) == 1))
			vals[REG_PHASE_STEP] = 32'((64'd1 << 32) / seg_eff);
		for (int n = 0; n < 8; n++) begin
			wr_en <= 1'b1;
			wr_index <= cfg_reg_t'(n);
			wr_data <= vals[n];
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	initial begin
		int vert_list [10] = '{0, 8, 16, 31, 32, 63, 64, 65, 66, 4095};
		int tri_list [10] = '{0, 31, 32, 63, 64, 65, 126, 127, 128, 4095};
		start <= 1'b0;
		action <= ACT_VERTEX;
		element_index <= '0;
		wr_en <= 1'b0;
		wr_index <= REG_SEGMENTS;
		wr_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 32 segments, unit radius and half height
		seg_eff = int'(RST_SEGMENTS);
		idle_on = 1'b1;
		for (int n = 0; n < 10; n++)
			send_request(ACT_VERTEX, IDX_W'(vert_list[n]));
		for (int n = 0; n < 10; n++)
			send_request(ACT_TRIANGLE, IDX_W'(tri_list[n]));
		for (int n = 0; n < ITEMS_PER_SETTING; n++)
			send_random();

		for (int p = 1; p <= SETTINGS; p++) begin
			start <= 1'b0;
			drain();
			load_setting(p);
			idle_on = (p != 4);
			for (int n = 0; n < ITEMS_PER_SETTING; n++)
				send_random();
		end

		start <= 1'b0;
		drain();
		repeat (10) @(posedge clk);

		$display("Summary: %0d vertex and %0d triangle requests over %0d register settings,",
			vertex_reqs, triangle_reqs, SETTINGS + 1);
		$display("Summary: %0d results checked, %0d mismatches", checked, mismatches);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/cmeg_pkg.sv
src/cmeg_sine_lut.sv
src/cylinder_mesh_element_generator.sv
tb/cylinder_mesh_element_checker.sv
tb/cylinder_mesh_element_generator_test.sv
